[sv/bre_pkg.sv]
// Shared types and constants for the body rate to Euler rate transform.
`default_nettype none
package bre_pkg;
   localparam int unsigned AngleWidth    = 16;
   localparam int unsigned RateWidth     = 16;
   localparam int unsigned OutWidth      = 24;
   localparam int unsigned TermWidth     = 32;
   localparam int unsigned ProdWidth     = 48;
   localparam int unsigned NumWidth      = 61;
   localparam int unsigned DenWidth      = 31;
   localparam int unsigned QuoWidth      = 38;
   localparam int unsigned HornerSteps   = 7;
   localparam int unsigned SincosLatency = 3 * HornerSteps + 4;
   localparam int unsigned MixLatency    = 2;
   localparam int unsigned DivLatency    = QuoWidth;
   localparam int unsigned FinishLatency = 3;
   localparam int unsigned TotalLatency  = SincosLatency + MixLatency + DivLatency
                                           + FinishLatency;

   localparam logic signed [33:0] Q30Pi     = 34'sd3373259426;
   localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
   localparam logic [31:0]        Q30One    = 32'd1073741824;
   localparam logic [31:0]        CosMin    = 32'd8388608;
   localparam logic signed [40:0] OutMax    = 41'sd8388607;
   localparam logic signed [40:0] OutMin    = -41'sd8388608;

   localparam logic [7:0]  SinDiv   [HornerSteps] = '{8'd210, 8'd156, 8'd110, 8'd72,
                                                       8'd42, 8'd20, 8'd6};
   localparam logic [7:0]  CosDiv   [HornerSteps] = '{8'd182, 8'd132, 8'd90, 8'd56,
                                                       8'd30, 8'd12, 8'd2};
   localparam logic [31:0] SinRecip [HornerSteps] = '{32'd20452225, 32'd27531841,
                                                       32'd39045157, 32'd59652323,
                                                       32'd102261126, 32'd214748364,
                                                       32'd715827882};
   localparam logic [31:0] CosRecip [HornerSteps] = '{32'd23598721, 32'd32537631,
                                                       32'd47721858, 32'd76695844,
                                                       32'd143165576, 32'd357913941,
                                                       32'd2147483648};

   typedef struct packed {
      logic signed [RateWidth-1:0] p;
      logic signed [16:0]          st15;
      logic signed [ProdWidth-1:0] pw;
      logic                        neg_quo;
      logic                        singular;
   } side_type;

   typedef struct packed {
      logic signed [RateWidth-1:0] p;
      logic signed [RateWidth-1:0] q;
      logic signed [RateWidth-1:0] r;
   } rates_type;
endpackage
`default_nettype wire

[sv/bre_sincos.sv]
// Pipelined Q30 sine and cosine by Horner evaluation of the series.
`default_nettype none
module bre_sincos (
   input  wire logic                                   clock,
   input  wire logic                                   adv,
   input  wire logic signed [bre_pkg::AngleWidth-1:0] angle,
   output logic signed [bre_pkg::TermWidth-1:0]        sin_out,
   output logic signed [bre_pkg::TermWidth-1:0]        cos_out
);
   localparam int unsigned Steps = bre_pkg::HornerSteps;
   localparam logic signed [32:0] One = $signed({1'b0, bre_pkg::Q30One});

   typedef struct packed {
      logic [31:0]        x2;
      logic signed [31:0] x;
      logic               neg;
   } carry_type;

   logic signed [33:0] x_full;
   logic signed [33:0] x_refl;
   logic               neg_refl;
   logic signed [31:0] x0_ff;
   logic signed [31:0] x1_ff;
   logic               neg0_ff;
   logic               neg1_ff;
   logic [30:0]        x0_mag;
   logic [61:0]        x0_sq;
   logic [31:0]        x2_ff;

   carry_type          car_in   [Steps];
   carry_type          car_a_ff [Steps];
   carry_type          car_b_ff [Steps];
   carry_type          car_c_ff [Steps];
   logic [30:0]        ts_in    [Steps];
   logic [30:0]        tc_in    [Steps];
   logic [31:0]        ms_a_ff  [Steps];
   logic [31:0]        mc_a_ff  [Steps];
   logic [31:0]        ms_b_ff  [Steps];
   logic [31:0]        mc_b_ff  [Steps];
   logic [31:0]        qs_b_ff  [Steps];
   logic [31:0]        qc_b_ff  [Steps];
   logic signed [31:0] ts_c_ff  [Steps];
   logic signed [31:0] tc_c_ff  [Steps];

   logic [30:0]        xf_mag;
   logic [61:0]        sf_prod;
   logic [31:0]        sm_ff;
   logic               sneg_ff;
   logic signed [31:0] cf_ff;
   logic               cneg_ff;
   logic signed [32:0] s_val;
   logic signed [32:0] s_clamp;
   logic signed [32:0] c_val;
   logic signed [32:0] c_clamp;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   always_comb begin
      x_full   = {angle[15], angle, 17'd0};
      x_refl   = x_full;
      neg_refl = 1'b0;
      if (x_full > bre_pkg::Q30HalfPi) begin
         x_refl   = bre_pkg::Q30Pi - x_full;
         neg_refl = 1'b1;
      end else if (x_full < -bre_pkg::Q30HalfPi) begin
         x_refl   = -bre_pkg::Q30Pi - x_full;
         neg_refl = 1'b1;
      end
   end

   assign x0_mag = x0_ff[31] ? 31'(-x0_ff) : x0_ff[30:0];
   assign x0_sq  = x0_mag * x0_mag;

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff   <= x_refl[31:0];
         neg0_ff <= neg_refl;
         x1_ff   <= x0_ff;
         neg1_ff <= neg0_ff;
         x2_ff   <= x0_sq[61:30];
      end
   end

   for (genvar j = 0; j < Steps; j++) begin : g_step
      logic [62:0] ps;
      logic [62:0] pc;
      logic [63:0] rs;
      logic [63:0] rc;
      logic [39:0] ds;
      logic [39:0] dc;
      logic [31:0] es;
      logic [31:0] ec;
      logic [31:0] qs;
      logic [31:0] qc;

      if (j == 0) begin : g_first
         assign car_in[j] = '{x2: x2_ff, x: x1_ff, neg: neg1_ff};
         assign ts_in[j]  = bre_pkg::Q30One[30:0];
         assign tc_in[j]  = bre_pkg::Q30One[30:0];
      end else begin : g_next
         assign car_in[j] = car_c_ff[j-1];
         assign ts_in[j]  = ts_c_ff[j-1][30:0];
         assign tc_in[j]  = tc_c_ff[j-1][30:0];
      end

      assign ps = car_in[j].x2 * ts_in[j];
      assign pc = car_in[j].x2 * tc_in[j];
      assign rs = ms_a_ff[j] * bre_pkg::SinRecip[j];
      assign rc = mc_a_ff[j] * bre_pkg::CosRecip[j];
      assign ds = qs_b_ff[j] * bre_pkg::SinDiv[j];
      assign dc = qc_b_ff[j] * bre_pkg::CosDiv[j];
      assign es = ms_b_ff[j] - ds[31:0];
      assign ec = mc_b_ff[j] - dc[31:0];
      assign qs = qs_b_ff[j] + {31'd0, (es >= {24'd0, bre_pkg::SinDiv[j]})};
      assign qc = qc_b_ff[j] + {31'd0, (ec >= {24'd0, bre_pkg::CosDiv[j]})};

      always_ff @(posedge clock) begin
         if (adv) begin
            ms_a_ff[j]  <= ps[61:30];
            mc_a_ff[j]  <= pc[61:30];
            car_a_ff[j] <= car_in[j];
            qs_b_ff[j]  <= rs[63:32];
            qc_b_ff[j]  <= rc[63:32];
            ms_b_ff[j]  <= ms_a_ff[j];
            mc_b_ff[j]  <= mc_a_ff[j];
            car_b_ff[j] <= car_a_ff[j];
            ts_c_ff[j]  <= $signed(bre_pkg::Q30One - qs);
            tc_c_ff[j]  <= $signed(bre_pkg::Q30One - qc);
            car_c_ff[j] <= car_b_ff[j];
         end
      end
   end

   assign xf_mag  = car_c_ff[Steps-1].x[31] ? 31'(-car_c_ff[Steps-1].x)
                                             : car_c_ff[Steps-1].x[30:0];
   assign sf_prod = xf_mag * ts_c_ff[Steps-1][30:0];

   always_comb begin
      s_val   = sneg_ff ? -$signed({1'b0, sm_ff}) : $signed({1'b0, sm_ff});
      s_clamp = s_val;
      if (s_val > One) begin
         s_clamp = One;
      end else if (s_val < -One) begin
         s_clamp = -One;
      end
      c_val = 33'(cf_ff);
      if (c_val > One) begin
         c_val = One;
      end else if (c_val < -One) begin
         c_val = -One;
      end
      c_clamp = cneg_ff ? -c_val : c_val;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_ff   <= sf_prod[61:30];
         sneg_ff <= car_c_ff[Steps-1].x[31];
         cf_ff   <= tc_c_ff[Steps-1];
         cneg_ff <= car_c_ff[Steps-1].neg;
         sin_ff  <= s_clamp[31:0];
         cos_ff  <= c_clamp[31:0];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule
`default_nettype wire

[sv/bre_mix.sv]
// Rate products, pitch singularity guard and divider operand set-up.
`default_nettype none
module bre_mix (
   input  wire logic                                  clock,
   input  wire logic                                  adv,
   input  wire logic signed [bre_pkg::TermWidth-1:0]  sin_phi,
   input  wire logic signed [bre_pkg::TermWidth-1:0]  cos_phi,
   input  wire logic signed [bre_pkg::TermWidth-1:0]  sin_theta,
   input  wire logic signed [bre_pkg::TermWidth-1:0]  cos_theta,
   input  wire bre_pkg::rates_type                     rates,
   output logic [bre_pkg::NumWidth-1:0]                num_out,
   output logic [bre_pkg::DenWidth-1:0]                den_out,
   output bre_pkg::side_type                           side_out
);
   localparam logic signed [31:0] CosMinS = $signed(bre_pkg::CosMin);

   logic                                singular;
   logic signed [31:0]                  ct_fix;
   logic [30:0]                         ct_mag;
   logic [30:0]                         st_abs;
   logic [15:0]                         st_mag;
   logic signed [16:0]                  st15;
   logic signed [bre_pkg::ProdWidth-1:0] spq_ff;
   logic signed [bre_pkg::ProdWidth-1:0] cpr_ff;
   logic signed [bre_pkg::ProdWidth-1:0] cpq_ff;
   logic signed [bre_pkg::ProdWidth-1:0] spr_ff;
   logic signed [16:0]                  st15_ff;
   logic signed [bre_pkg::RateWidth-1:0] p1_ff;
   logic [30:0]                         ctmag_ff;
   logic                                ctneg_ff;
   logic                                sing_ff;
   logic signed [bre_pkg::ProdWidth-1:0] w;
   logic signed [bre_pkg::ProdWidth-1:0] pw;
   logic [46:0]                         w_mag;
   logic [bre_pkg::NumWidth-1:0]        num_ff;
   logic [bre_pkg::DenWidth-1:0]        den_ff;
   bre_pkg::side_type                   side_ff;

   always_comb begin
      singular = (cos_theta < CosMinS) && (cos_theta > -CosMinS);
      ct_fix   = cos_theta;
      if (singular) begin
         ct_fix = cos_theta[31] ? -CosMinS : CosMinS;
      end
      ct_mag = ct_fix[31] ? 31'(-ct_fix) : ct_fix[30:0];
      st_abs = sin_theta[31] ? 31'(-sin_theta) : sin_theta[30:0];
      st_mag = st_abs[30:15];
      st15   = sin_theta[31] ? -$signed({1'b0, st_mag}) : $signed({1'b0, st_mag});
   end

   assign w     = spq_ff + cpr_ff;
   assign pw    = cpq_ff - spr_ff;
   assign w_mag = w[47] ? 47'(-w) : w[46:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         spq_ff   <= sin_phi * rates.q;
         cpr_ff   <= cos_phi * rates.r;
         cpq_ff   <= cos_phi * rates.q;
         spr_ff   <= sin_phi * rates.r;
         st15_ff  <= st15;
         p1_ff    <= rates.p;
         ctmag_ff <= ct_mag;
         ctneg_ff <= ct_fix[31];
         sing_ff  <= singular;

         num_ff           <= {w_mag, 14'd0};
         den_ff           <= ctmag_ff;
         side_ff.p        <= p1_ff;
         side_ff.st15     <= st15_ff;
         side_ff.pw       <= pw;
         side_ff.neg_quo  <= w[47] ^ ctneg_ff;
         side_ff.singular <= sing_ff;
      end
   end

   assign num_out  = num_ff;
   assign den_out  = den_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

[sv/bre_divider.sv]
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module bre_divider (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [bre_pkg::NumWidth-1:0]  num,
   input  wire logic [bre_pkg::DenWidth-1:0]  den,
   input  wire bre_pkg::side_type              side_in,
   output logic [bre_pkg::QuoWidth-1:0]        quo_out,
   output bre_pkg::side_type                   side_out
);
   localparam int unsigned Qw = bre_pkg::QuoWidth;
   localparam int unsigned Dw = bre_pkg::DenWidth;
   localparam int unsigned Nw = bre_pkg::NumWidth;

   logic [Dw-1:0]     rem_in   [Qw];
   logic [Qw-1:0]     quo_in   [Qw];
   logic [Qw-1:0]     low_in   [Qw];
   logic [Dw-1:0]     den_in   [Qw];
   bre_pkg::side_type side_in_a[Qw];
   logic [Dw-1:0]     rem_ff   [Qw];
   logic [Qw-1:0]     quo_ff   [Qw];
   logic [Qw-1:0]     low_ff   [Qw];
   logic [Dw-1:0]     den_ff   [Qw];
   bre_pkg::side_type side_ff  [Qw];

   for (genvar i = 0; i < Qw; i++) begin : g_bit
      logic [Dw:0] sh;
      logic [Dw:0] diff;
      logic        ge;

      if (i == 0) begin : g_first
         assign rem_in[i]    = Dw'(num[Nw-1:Qw]);
         assign quo_in[i]    = '0;
         assign low_in[i]    = num[Qw-1:0];
         assign den_in[i]    = den;
         assign side_in_a[i] = side_in;
      end else begin : g_next
         assign rem_in[i]    = rem_ff[i-1];
         assign quo_in[i]    = quo_ff[i-1];
         assign low_in[i]    = low_ff[i-1];
         assign den_in[i]    = den_ff[i-1];
         assign side_in_a[i] = side_ff[i-1];
      end

      assign sh   = {rem_in[i], low_in[i][Qw-1-i]};
      assign ge   = sh >= {1'b0, den_in[i]};
      assign diff = sh - {1'b0, den_in[i]};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= ge ? diff[Dw-1:0] : sh[Dw-1:0];
            quo_ff[i]  <= {quo_in[i][Qw-2:0], ge};
            low_ff[i]  <= low_in[i];
            den_ff[i]  <= den_in[i];
            side_ff[i] <= side_in_a[i];
         end
      end
   end

   assign quo_out  = quo_ff[Qw-1];
   assign side_out = side_ff[Qw-1];
endmodule
`default_nettype wire

[sv/bre_finish.sv]
// Roll term, rounding to rate units and output saturation.
`default_nettype none
module bre_finish (
   input  wire logic                              clock,
   input  wire logic                              adv,
   input  wire logic [bre_pkg::QuoWidth-1:0]      quo,
   input  wire bre_pkg::side_type                  side_in,
   output logic signed [bre_pkg::OutWidth-1:0]     roll_out,
   output logic signed [bre_pkg::OutWidth-1:0]     pitch_out,
   output logic signed [bre_pkg::OutWidth-1:0]     yaw_out,
   output logic                                    flag_out
);
   typedef struct packed {
      logic                                clip;
      logic signed [bre_pkg::OutWidth-1:0] value;
   } sat_type;

   function automatic sat_type sat_out(input logic signed [40:0] v);
      sat_type s;
      s.clip  = 1'b0;
      s.value = v[23:0];
      if (v > bre_pkg::OutMax) begin
         s.clip  = 1'b1;
         s.value = bre_pkg::OutMax[23:0];
      end else if (v < bre_pkg::OutMin) begin
         s.clip  = 1'b1;
         s.value = bre_pkg::OutMin[23:0];
      end
      return s;
   endfunction

   logic signed [38:0] yaw14;
   logic signed [55:0] prod;
   logic [46:0]        pw_mag;
   logic [47:0]        pw_sum;
   logic signed [18:0] pitch_r;
   logic signed [55:0] prod_ff;
   logic signed [38:0] yaw14_ff;
   logic signed [18:0] pitch1_ff;
   logic signed [15:0] p1_ff;
   logic               sing1_ff;

   logic [54:0]        prod_mag;
   logic signed [40:0] tq;
   logic signed [40:0] roll14;
   logic [37:0]        ymag;
   logic [38:0]        ysum;
   logic signed [25:0] yaw_r;
   sat_type            pitch_sat;
   logic signed [40:0] roll14_ff;
   logic signed [25:0] yaw_r_ff;
   logic signed [23:0] pitch2_ff;
   logic               flag2_ff;

   logic [39:0]        rmag;
   logic [40:0]        rsum;
   logic signed [27:0] roll_r;
   sat_type            roll_sat;
   sat_type            yaw_sat;
   logic signed [23:0] roll_ff;
   logic signed [23:0] pitch_ff;
   logic signed [23:0] yaw_ff;
   logic               flag_ff;

   always_comb begin
      yaw14   = side_in.neg_quo ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      prod    = yaw14 * side_in.st15;
      pw_mag  = side_in.pw[47] ? 47'(-side_in.pw) : side_in.pw[46:0];
      pw_sum  = {1'b0, pw_mag} + 48'd536870912;
      pitch_r = side_in.pw[47] ? -$signed({1'b0, pw_sum[47:30]})
                               : $signed({1'b0, pw_sum[47:30]});
   end

   always_comb begin
      prod_mag  = prod_ff[55] ? 55'(-prod_ff) : prod_ff[54:0];
      tq        = prod_ff[55] ? -$signed({1'b0, prod_mag[54:15]})
                              : $signed({1'b0, prod_mag[54:15]});
      roll14    = $signed({{11{p1_ff[15]}}, p1_ff, 14'd0}) + tq;
      ymag      = yaw14_ff[38] ? 38'(-yaw14_ff) : yaw14_ff[37:0];
      ysum      = {1'b0, ymag} + 39'd8192;
      yaw_r     = yaw14_ff[38] ? -$signed({1'b0, ysum[38:14]}) : $signed({1'b0, ysum[38:14]});
      pitch_sat = sat_out(41'(pitch1_ff));
   end

   always_comb begin
      rmag     = roll14_ff[40] ? 40'(-roll14_ff) : roll14_ff[39:0];
      rsum     = {1'b0, rmag} + 41'd8192;
      roll_r   = roll14_ff[40] ? -$signed({1'b0, rsum[40:14]}) : $signed({1'b0, rsum[40:14]});
      roll_sat = sat_out(41'(roll_r));
      yaw_sat  = sat_out(41'(yaw_r_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod;
         yaw14_ff  <= yaw14;
         pitch1_ff <= pitch_r;
         p1_ff     <= side_in.p;
         sing1_ff  <= side_in.singular;

         roll14_ff <= roll14;
         yaw_r_ff  <= yaw_r;
         pitch2_ff <= pitch_sat.value;
         flag2_ff  <= sing1_ff | pitch_sat.clip;

         roll_ff   <= roll_sat.value;
         yaw_ff    <= yaw_sat.value;
         pitch_ff  <= pitch2_ff;
         flag_ff   <= flag2_ff | roll_sat.clip | yaw_sat.clip;
      end
   end

   assign roll_out  = roll_ff;
   assign pitch_out = pitch_ff;
   assign yaw_out   = yaw_ff;
   assign flag_out  = flag_ff;
endmodule
`default_nettype wire

[sv/body_rate_to_euler_rate.sv]
// Top level: gyro body rates to ZYX Euler angle rates, fully pipelined.
// A req transfer passes through 25 sine/cosine, 2 product, 38 divider and
// 3 rounding stages to reach its rsp result; the divider stages are most of them.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits on rsp_ready, and req_ready is low then and while reset is high.
// Reset clears the valid bits of the pipeline; data registers are not reset.
`default_nettype none
module body_rate_to_euler_rate (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [bre_pkg::AngleWidth-1:0] req_roll_angle,
   input  wire logic signed [bre_pkg::AngleWidth-1:0] req_pitch_angle,
   input  wire logic signed [bre_pkg::RateWidth-1:0]  req_rate_p,
   input  wire logic signed [bre_pkg::RateWidth-1:0]  req_rate_q,
   input  wire logic signed [bre_pkg::RateWidth-1:0]  req_rate_r,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [bre_pkg::OutWidth-1:0]        rsp_roll_rate_out,
   output logic signed [bre_pkg::OutWidth-1:0]        rsp_pitch_rate_out,
   output logic signed [bre_pkg::OutWidth-1:0]        rsp_yaw_rate_out,
   output logic                                       rsp_saturated
);
   localparam int unsigned Lat = bre_pkg::TotalLatency;
   localparam int unsigned Dly = bre_pkg::SincosLatency;

   logic                                    adv;
   logic [Lat-1:0]                          vld_ff;
   bre_pkg::rates_type                      rates_ff [Dly];
   logic signed [bre_pkg::TermWidth-1:0]    sin_phi;
   logic signed [bre_pkg::TermWidth-1:0]    cos_phi;
   logic signed [bre_pkg::TermWidth-1:0]    sin_theta;
   logic signed [bre_pkg::TermWidth-1:0]    cos_theta;
   logic [bre_pkg::NumWidth-1:0]            div_num;
   logic [bre_pkg::DenWidth-1:0]            div_den;
   bre_pkg::side_type                       mix_side;
   logic [bre_pkg::QuoWidth-1:0]            div_quo;
   bre_pkg::side_type                       div_side;

   assign adv       = !vld_ff[Lat-1] || rsp_ready;
   assign req_ready = adv && !reset;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rates_ff[0] <= '{p: req_rate_p, q: req_rate_q, r: req_rate_r};
         for (int i = 1; i < Dly; i++) begin
            rates_ff[i] <= rates_ff[i-1];
         end
      end
   end

   bre_sincos u_sincos_phi (
      .clock   (clock),
      .adv     (adv),
      .angle   (req_roll_angle),
      .sin_out (sin_phi),
      .cos_out (cos_phi)
   );

   bre_sincos u_sincos_theta (
      .clock   (clock),
      .adv     (adv),
      .angle   (req_pitch_angle),
      .sin_out (sin_theta),
      .cos_out (cos_theta)
   );

   bre_mix u_mix (
      .clock     (clock),
      .adv       (adv),
      .sin_phi   (sin_phi),
      .cos_phi   (cos_phi),
      .sin_theta (sin_theta),
      .cos_theta (cos_theta),
      .rates     (rates_ff[Dly-1]),
      .num_out   (div_num),
      .den_out   (div_den),
      .side_out  (mix_side)
   );

   bre_divider u_divider (
      .clock    (clock),
      .adv      (adv),
      .num      (div_num),
      .den      (div_den),
      .side_in  (mix_side),
      .quo_out  (div_quo),
      .side_out (div_side)
   );

   bre_finish u_finish (
      .clock     (clock),
      .adv       (adv),
      .quo       (div_quo),
      .side_in   (div_side),
      .roll_out  (rsp_roll_rate_out),
      .pitch_out (rsp_pitch_rate_out),
      .yaw_out   (rsp_yaw_rate_out),
      .flag_out  (rsp_saturated)
   );

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("transfer did not enter the pipeline");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_rate_out <= 24'sd131072 &&
                     rsp_pitch_rate_out >= -24'sd131072))
      else $error("pitch rate beyond its reachable range");
endmodule
`default_nettype wire
